FILE: rtl/tcw_pkg.sv
// Package for the text console writer: screen geometry, character codes,
// operation codes, request and response structs and the controller states.
// Depends on nothing; text_console_writer_unit imports it.
package tcw_pkg;

   localparam int SCREEN_WIDTH  = 80;
   localparam int SCREEN_HEIGHT = 25;
   localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W        = $clog2(CELL_COUNT);
   localparam int CNT_W         = $clog2(CELL_COUNT + 1);

   localparam logic [7:0] BLANK_CHAR     = 8'h20;
   localparam logic [7:0] BLANK_ATTR     = 8'h07;
   localparam logic [7:0] CODE_NEWLINE   = 8'd10;
   localparam logic [7:0] CODE_BACKSPACE = 8'd8;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  ch;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic [10:0] cursor_pos;
      logic        cursor_write;
      logic [7:0]  cell_char;
      logic [7:0]  cell_attr;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL
   } tcw_state_type;

   function automatic logic [10:0] linear_pos(logic [4:0] row, logic [6:0] col);
      return 11'(int'(row) * SCREEN_WIDTH + int'(col));
   endfunction

endpackage

FILE: rtl/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/text_console_writer_unit.sv
// Top level of the text console writer: cursor control, clear and scroll
// sequencer around one character RAM and one attribute RAM.
// Depends on tcw_pkg and tcw_ram.
//
// A request is taken at a rising edge with start high and busy low. Every
// request gives exactly one response, shown for one cycle with rsp_strobe high.
// A put of a character, newline or backspace, an unused op and a read of an
// index past the last cell answer in the cycle after acceptance; busy stays
// low, so the next request may follow at once. A read inside the screen goes
// through ST_READ, where the registered RAM data is taken, and then answers. A
// put that moves the cursor past the last row starts a scroll that copies one
// cell per cycle through the character RAM port pair, then answers. A clear
// op writes one cell per cycle into both RAMs, then answers. After reset the
// same clearing pass runs with busy high and no response; csr writes are taken
// at any time. The receiver cannot stall, so no response is ever held back.
module text_console_writer_unit (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  tcw_pkg::req_type req_data,
   output logic            rsp_strobe,
   output tcw_pkg::rsp_type rsp_data,
   input  logic            csr_write_enable,
   input  logic            csr_write_data
);

   import tcw_pkg::*;

   tcw_state_type state_ff, state_in;
   logic [CNT_W-1:0] sweep_ff, sweep_in;
   logic [6:0] col_ff, col_in;
   logic [4:0] row_ff, row_in;
   logic cur_en_ff;
   logic pend_rsp_ff, pend_rsp_in;
   logic pend_wr_ff, pend_wr_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic char_we, attr_we;
   logic [ADDR_W-1:0] char_waddr, char_raddr, attr_waddr, attr_raddr;
   logic [7:0] char_wdata, attr_wdata, char_rdata, attr_rdata;

   tcw_ram #(.WIDTH(8), .DEPTH(CELL_COUNT)) u_char_ram (
      .clock  (clock),
      .wr_en  (char_we),
      .wr_addr(char_waddr),
      .wr_data(char_wdata),
      .rd_addr(char_raddr),
      .rd_data(char_rdata)
   );

   tcw_ram #(.WIDTH(8), .DEPTH(CELL_COUNT)) u_attr_ram (
      .clock  (clock),
      .wr_en  (attr_we),
      .wr_addr(attr_waddr),
      .wr_data(attr_wdata),
      .rd_addr(attr_raddr),
      .rd_data(attr_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         cur_en_ff    <= 1'b1;
         pend_rsp_ff  <= 1'b0;
         pend_wr_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pend_rsp_ff  <= pend_rsp_in;
         pend_wr_ff   <= pend_wr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            cur_en_ff <= csr_write_data;
         end
      end
      rsp_ff <= rsp_in;
   end

   always_comb begin
      logic [7:0] col_p1;
      logic       row_inc;
      logic       do_scroll;
      logic [6:0] col_n;
      logic [4:0] row_n;
      logic [CNT_W-1:0] sweep_dec;
      logic [CNT_W-1:0] sweep_src;

      col_p1    = {1'b0, col_ff} + 8'd1;
      row_inc   = 1'b0;
      col_n     = col_ff;
      row_n     = row_ff;
      do_scroll = 1'b0;
      sweep_dec = sweep_ff - CNT_W'(1);
      sweep_src = sweep_ff + CNT_W'(SCREEN_WIDTH);

      state_in     = state_ff;
      sweep_in     = sweep_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pend_rsp_in  = pend_rsp_ff;
      pend_wr_in   = pend_wr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.cursor_col = col_ff;
      rsp_in.cursor_row = row_ff;
      rsp_in.cursor_pos = linear_pos(row_ff, col_ff);

      char_we    = 1'b0;
      char_waddr = linear_pos(row_ff, col_ff);
      char_wdata = req_data.ch;
      char_raddr = ADDR_W'(req_data.cell_index);
      attr_we    = 1'b0;
      attr_waddr = sweep_ff[ADDR_W-1:0];
      attr_wdata = BLANK_ATTR;
      attr_raddr = ADDR_W'(req_data.cell_index);

      if (req_data.ch == CODE_NEWLINE) begin
         col_n   = '0;
         row_inc = 1'b1;
      end else if (req_data.ch == CODE_BACKSPACE) begin
         if (col_ff != '0) begin
            col_n = col_ff - 7'd1;
         end
      end else if (int'(col_p1) >= SCREEN_WIDTH) begin
         col_n   = '0;
         row_inc = 1'b1;
      end else begin
         col_n = col_p1[6:0];
      end
      if (row_inc) begin
         if (int'(row_ff) + 1 >= SCREEN_HEIGHT) begin
            do_scroll = 1'b1;
         end else begin
            row_n = row_ff + 5'd1;
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            char_we    = 1'b1;
            char_waddr = sweep_ff[ADDR_W-1:0];
            char_wdata = BLANK_CHAR;
            attr_we    = 1'b1;
            if (sweep_ff == CNT_W'(CELL_COUNT - 1)) begin
               state_in     = ST_IDLE;
               sweep_in     = '0;
               rsp_valid_in = pend_rsp_ff;
               pend_rsp_in  = 1'b0;
            end else begin
               sweep_in = sweep_ff + CNT_W'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               case (req_data.op)
                  OP_PUT: begin
                     char_we = (req_data.ch != CODE_NEWLINE) &&
                               (req_data.ch != CODE_BACKSPACE);
                     col_in = col_n;
                     row_in = row_n;
                     if (do_scroll) begin
                        state_in   = ST_SCROLL;
                        sweep_in   = '0;
                        pend_wr_in = cur_en_ff;
                     end else begin
                        rsp_valid_in        = 1'b1;
                        rsp_in.cursor_col   = col_n;
                        rsp_in.cursor_row   = row_n;
                        rsp_in.cursor_pos   = linear_pos(row_n, col_n);
                        rsp_in.cursor_write = cur_en_ff;
                     end
                  end
                  OP_CLEAR: begin
                     state_in    = ST_CLEAR;
                     sweep_in    = '0;
                     col_in      = '0;
                     row_in      = '0;
                     pend_rsp_in = 1'b1;
                  end
                  OP_READ: begin
                     if (32'(req_data.cell_index) < CELL_COUNT) begin
                        state_in = ST_READ;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in         = ST_IDLE;
            rsp_valid_in     = 1'b1;
            rsp_in.cell_char = char_rdata;
            rsp_in.cell_attr = attr_rdata;
         end
         ST_SCROLL: begin
            char_we    = (sweep_ff != '0);
            char_waddr = sweep_dec[ADDR_W-1:0];
            char_wdata = char_rdata;
            if (sweep_ff == CNT_W'(CELL_COUNT - SCREEN_WIDTH)) begin
               char_raddr          = '0;
               state_in            = ST_IDLE;
               sweep_in            = '0;
               rsp_valid_in        = 1'b1;
               rsp_in.cursor_write = pend_wr_ff;
            end else begin
               char_raddr = sweep_src[ADDR_W-1:0];
               sweep_in   = sweep_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule
